// ===== src/kops_pkg.sv =====
`timescale 1ns / 1ps
// kops_pkg: shared types and constants for the key-off power sequencer
// no dependencies

package kops_pkg;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int S_DATA_W   = 8;
  localparam int M_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WAIT       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_DELAY = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY          = 8'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST       = 16'd500;
  localparam logic [CFG_W-1:0] MAX_WAIT_RST       = 16'd30000;
  localparam logic [CFG_W-1:0] SHUTDOWN_DELAY_RST = 16'd15000;
  localparam logic [CFG_W-1:0] RETRY_RST          = 16'd1000;

  typedef struct packed {
    logic key_sense_raw;
    logic charge_session_active;
    logic controller_off;
    logic gateway_response_sent;
    logic gateway_request_pending;
    logic notice_link_ready;
  } tick_in_t;

  typedef struct packed {
    logic stable_low;
    logic stable_high;
    logic wait_expired;
  } key_status_t;

  typedef struct packed {
    logic aux_relay_on;
    logic display_relay_on;
    logic notice_attempt;
    logic notice_delivered;
    logic sleep_request;
  } tick_out_t;

endpackage

// ===== src/kops_key_filter.sv =====
`timescale 1ns / 1ps
// kops_key_filter: two-way debounce of the key sense line and key-off wait timer
// depends on kops_pkg

module kops_key_filter import kops_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             key,
  input  logic [CFG_W-1:0] debounce_ms,
  input  logic [CFG_W-1:0] max_wait_ms,
  output key_status_t      status
);

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic [TIMER_BITS-1:0] ticks_high;
  logic [TIMER_BITS-1:0] ticks_low;
  logic [TIMER_BITS-1:0] high_inc;
  logic [TIMER_BITS-1:0] low_inc;

  always_comb begin
    high_inc = (ticks_high == '1) ? ticks_high : ticks_high + 1'b1;
    low_inc  = (ticks_low == '1) ? ticks_low : ticks_low + 1'b1;
    status.stable_low   = !key && (CW'(high_inc) > CW'(debounce_ms));
    status.stable_high  = key && (CW'(low_inc) > CW'(debounce_ms));
    status.wait_expired = CW'(high_inc) >= CW'(max_wait_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_high <= '0;
      ticks_low  <= '0;
    end else if (step) begin
      ticks_high <= key ? '0 : high_inc;
      ticks_low  <= key ? low_inc : '0;
    end
  end

endmodule

// ===== src/kops_shutdown_ctrl.sv =====
`timescale 1ns / 1ps
// kops_shutdown_ctrl: aux and display relays, shutdown notice retries and sleep decision
// depends on kops_pkg

module kops_shutdown_ctrl import kops_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tick_in_t         tick,
  input  key_status_t      status,
  input  logic [CFG_W-1:0] shutdown_delay_ms,
  input  logic [CFG_W-1:0] retry_ms,
  output tick_out_t        result
);

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic [TIMER_BITS-1:0] ticks_attempt;
  logic [TIMER_BITS-1:0] ticks_notice;
  logic                  notice_done;
  logic                  display_relay;

  logic [TIMER_BITS-1:0] attempt_inc;
  logic [TIMER_BITS-1:0] notice_inc;
  logic [TIMER_BITS-1:0] ticks_attempt_next;
  logic [TIMER_BITS-1:0] ticks_notice_next;
  logic                  notice_done_next;
  logic                  display_relay_next;
  logic                  attempt;
  logic                  delivered;

  always_comb begin
    attempt_inc        = (ticks_attempt == '1) ? ticks_attempt : ticks_attempt + 1'b1;
    notice_inc         = (ticks_notice == '1) ? ticks_notice : ticks_notice + 1'b1;
    ticks_attempt_next = attempt_inc;
    ticks_notice_next  = notice_inc;
    notice_done_next   = notice_done;
    display_relay_next = display_relay;
    attempt            = 1'b0;
    delivered          = 1'b0;
    if (status.stable_high) begin
      display_relay_next = 1'b1;
      notice_done_next   = 1'b0;
    end else if (status.stable_low && display_relay) begin
      if (status.wait_expired) begin
        display_relay_next = 1'b0;
      end else if (!notice_done) begin
        if (CW'(attempt_inc) >= CW'(retry_ms)) begin
          ticks_attempt_next = '0;
          attempt            = 1'b1;
          if (tick.notice_link_ready) begin
            delivered         = 1'b1;
            notice_done_next  = 1'b1;
            ticks_notice_next = '0;
          end
        end
      end else if (CW'(notice_inc) >= CW'(shutdown_delay_ms)) begin
        display_relay_next = 1'b0;
      end
    end

    result.aux_relay_on     = status.stable_high || tick.charge_session_active;
    result.display_relay_on = display_relay_next;
    result.notice_attempt   = attempt;
    result.notice_delivered = delivered;
    result.sleep_request    = !tick.key_sense_raw && tick.controller_off &&
                              !display_relay_next &&
                              (tick.gateway_response_sent ||
                               (!tick.gateway_request_pending && status.stable_low));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_attempt <= '1;
      ticks_notice  <= '0;
      notice_done   <= 1'b0;
      display_relay <= 1'b0;
    end else if (step) begin
      ticks_attempt <= ticks_attempt_next;
      ticks_notice  <= ticks_notice_next;
      notice_done   <= notice_done_next;
      display_relay <= display_relay_next;
    end
  end

endmodule

// ===== src/key_off_power_sequencer.sv =====
`timescale 1ns / 1ps
// key_off_power_sequencer: top level, input register, config registers, result register
// depends on kops_pkg, kops_key_filter, kops_shutdown_ctrl

// One tick item in, one result item out, sustained at one item per clock while m_tready
// holds. A tick transfer is captured in an input register, evaluated against the timer
// state by short logic and written to the output register, which offers the result
// until it transfers; a stalled output holds the tick in the input register. The output
// register lets a new tick enter while the previous result waits. All timers are
// TIMER_BITS wide and saturate at all ones.
// Configuration writes are accepted every cycle and should only be issued while
// the block is idle.

module key_off_power_sequencer import kops_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // key_sense_raw, charge_session_active, controller_off, gateway_response_sent,
  // gateway_request_pending, notice_link_ready, zero fill
  input  logic [S_DATA_W-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // aux_relay_on, display_relay_on, notice_attempt, notice_delivered,
  // sleep_request, zero fill
  output logic [M_DATA_W-1:0]  m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] max_wait_ms;
  logic [CFG_W-1:0] shutdown_delay_ms;
  logic [CFG_W-1:0] retry_ms;

  logic        in_valid;
  tick_in_t    in_tick;
  tick_in_t    tick;
  logic        step;
  logic        out_load;
  key_status_t status;
  tick_out_t   result;
  tick_out_t   out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms       <= DEBOUNCE_RST;
      max_wait_ms       <= MAX_WAIT_RST;
      shutdown_delay_ms <= SHUTDOWN_DELAY_RST;
      retry_ms          <= RETRY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:       debounce_ms       <= cfg_data;
        REG_MAX_WAIT:       max_wait_ms       <= cfg_data;
        REG_SHUTDOWN_DELAY: shutdown_delay_ms <= cfg_data;
        REG_RETRY:          retry_ms          <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign out_load = !m_tvalid || m_tready;
  assign step     = in_valid && out_load;
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_tick <= tick_in_t'(s_tdata[5:0]);
    end
  end

  // tdata bit 0 lands in the last struct member
  assign tick.key_sense_raw           = in_tick.notice_link_ready;
  assign tick.charge_session_active   = in_tick.gateway_request_pending;
  assign tick.controller_off          = in_tick.gateway_response_sent;
  assign tick.gateway_response_sent   = in_tick.controller_off;
  assign tick.gateway_request_pending = in_tick.charge_session_active;
  assign tick.notice_link_ready       = in_tick.key_sense_raw;

  kops_key_filter #(
    .TIMER_BITS (TIMER_BITS)
  ) u_key_filter (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .key         (tick.key_sense_raw),
    .debounce_ms (debounce_ms),
    .max_wait_ms (max_wait_ms),
    .status      (status)
  );

  kops_shutdown_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_shutdown_ctrl (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .tick              (tick),
    .status            (status),
    .shutdown_delay_ms (shutdown_delay_ms),
    .retry_ms          (retry_ms),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign m_tdata = {3'b000, out_res.sleep_request, out_res.notice_delivered,
                    out_res.notice_attempt, out_res.display_relay_on,
                    out_res.aux_relay_on};

endmodule

// ===== src/kops_checker.sv =====
`timescale 1ns / 1ps
// kops_port_checker: port-level assertions for the key-off power sequencer
// depends on kops_pkg; bound to key_off_power_sequencer

module kops_port_checker import kops_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // delivery only on an attempt
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[2])
    else $error("notice delivered without attempt");

  // an attempt keeps the display relay on
  a_attempt_relay: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("notice attempt with display relay off");

  // sleep never with display relay on
  a_sleep_relay: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> !m_tdata[1])
    else $error("sleep request with display relay on");

endmodule

bind key_off_power_sequencer kops_port_checker u_kops_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
